// ===== rtl/core/spc_pkg.sv =====
// ----------------------------------------------------------------------------
// spc_pkg: shared definitions for the segmented prime counter
// Sizes, derived widths and the word types of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

package spc_pkg;

  localparam int unsigned WINDOW_SIZE = 4096;
  localparam int unsigned BASE_LIMIT  = 65536;
  localparam int unsigned VALUE_BITS  = 32;

  localparam int unsigned COUNT_W = 13;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam int unsigned WA_W   = $clog2(WINDOW_SIZE);
  localparam int unsigned BA_W   = $clog2(BASE_LIMIT);
  localparam int unsigned ROOT_W = (VALUE_BITS + 1) / 2;
  localparam int unsigned RB_W   = $clog2(ROOT_W);
  localparam int unsigned PW     = BA_W + 1;
  localparam int unsigned MW     = (ROOT_W > PW) ? ROOT_W : PW;
  localparam int unsigned CW     = (2 * MW > VALUE_BITS + 2) ? 2 * MW : VALUE_BITS + 2;
  localparam int unsigned DC_W   = $clog2(VALUE_BITS);

  typedef struct packed {
    logic [VALUE_BITS-1:0] low_bound;
    logic [VALUE_BITS-1:0] high_bound;
  } spc_in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] prime_count;
    logic               range_error;
  } spc_out_t;

endpackage

`default_nettype wire

// ===== rtl/core/segmented_prime_count.sv =====
// ----------------------------------------------------------------------------
// segmented_prime_count: prime count over an inclusive range
// Segmented sieve with a one-bit base sieve store, a window bitmap and a
// bit-serial remainder unit, run by a small sequencer.
// ----------------------------------------------------------------------------
// Usage: present {low_bound, high_bound} on in_data_i with in_valid_i. The
// word is taken when in_stall_o is low; in_stall_o stays high while a query
// is worked on. One result word {prime_count, range_error} leaves on
// out_data_o with out_valid_o and is held while out_stall_i is high; the
// next query may be taken while that word still waits.
// Sequence: an empty or too wide range goes straight to its result word.
//   Otherwise the sequencer finds the root bit by bit, fills the base store
//   up to L and crosses off the base marks of each prime p with p*p <= L,
//   fills the window, finds the remainder and start for each prime p <= L and
//   crosses off its window hits, then counts the window, with L = isqrt(high_bound).
// The sequencer passes through its idle state
// before the next word is taken. The single write/read
// port of each bit store and the one-bit-per-cycle remainder unit set the run time.
// Reset: asynchronous, active low; the sequencer goes idle and no result is
// pending. The bit stores are not cleared; every query rewrites what it reads.
// ----------------------------------------------------------------------------
`default_nettype none

module segmented_prime_count (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  spc_pkg::spc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output spc_pkg::spc_out_t out_data_o
);
  import spc_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SQRT   = 4'd1;
  localparam logic [3:0] S_BFILL  = 4'd2;
  localparam logic [3:0] S_BTEST  = 4'd3;
  localparam logic [3:0] S_BCHK   = 4'd4;
  localparam logic [3:0] S_BMARK  = 4'd5;
  localparam logic [3:0] S_WFILL  = 4'd6;
  localparam logic [3:0] S_WTEST  = 4'd7;
  localparam logic [3:0] S_WCHK   = 4'd8;
  localparam logic [3:0] S_DIV    = 4'd9;
  localparam logic [3:0] S_WSTART = 4'd10;
  localparam logic [3:0] S_WMARK  = 4'd11;
  localparam logic [3:0] S_CRD    = 4'd12;
  localparam logic [3:0] S_CLAST  = 4'd13;
  localparam logic [3:0] S_DONE   = 4'd14;

  logic [3:0]            state_q, state_d;
  logic [VALUE_BITS-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [WA_W-1:0]       last_q, last_d, k_q, k_d;
  logic [ROOT_W-1:0]     root_q, root_d;
  logic [RB_W-1:0]       rbit_q, rbit_d;
  logic [BA_W-1:0]       limit_q, limit_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic [PW-1:0]         p_q, p_d;
  logic [BA_W-1:0]       rem_q, rem_d;
  logic [VALUE_BITS-1:0] dvd_q, dvd_d;
  logic [DC_W-1:0]       dcnt_q, dcnt_d;
  logic [COUNT_W-1:0]    cnt_q, cnt_d, cnt_nx;
  logic                  rd_pend_q, rd_pend_d;
  spc_out_t              res_q, res_d;
  logic                  out_valid_q, out_valid_d;
  spc_out_t              out_q, out_d;

  logic            base_mem [BASE_LIMIT];
  logic            base_we, base_wd, base_rd_q;
  logic [BA_W-1:0] base_wa, base_ra;
  logic            win_mem [WINDOW_SIZE];
  logic            win_we, win_wd, win_rd_q;
  logic [WA_W-1:0] win_wa, win_ra;

  logic [VALUE_BITS-1:0] in_lo, in_hi, in_lo_c;
  logic [VALUE_BITS:0]   in_span;
  logic                  in_empty, in_wide;
  logic [ROOT_W-1:0]     cand, root_n;
  logic [MW-1:0]         mul_a;
  logic [2*MW-1:0]       prod;
  logic [CW-1:0]         prod_c, hi_c, lo_c, p_c, lim_c, start_v, start_m;
  logic [PW-1:0]         rem_sh, rem_nx;
  logic [WA_W-1:0]       widx;

  assign in_lo    = VALUE_BITS'(in_data_i.low_bound);
  assign in_hi    = VALUE_BITS'(in_data_i.high_bound);
  assign in_empty = (in_lo > in_hi) || (in_hi < VALUE_BITS'(2));
  assign in_lo_c  = (in_lo < VALUE_BITS'(2)) ? VALUE_BITS'(2) : in_lo;
  assign in_span  = (VALUE_BITS + 1)'(in_hi) - (VALUE_BITS + 1)'(in_lo_c);
  assign in_wide  = in_span >= (VALUE_BITS + 1)'(WINDOW_SIZE);

  // one squarer, shared by the root search and the p*p bounds
  assign cand   = root_q | (ROOT_W'(1) << rbit_q);
  assign mul_a  = (state_q == S_SQRT) ? MW'(cand) : MW'(p_q);
  assign prod   = (2 * MW)'(mul_a) * (2 * MW)'(mul_a);
  assign prod_c = CW'(prod);
  assign root_n = (prod_c <= CW'(hi_q)) ? cand : root_q;

  assign hi_c  = CW'(hi_q);
  assign lo_c  = CW'(lo_q);
  assign p_c   = CW'(p_q);
  assign lim_c = CW'(limit_q);

  // restoring remainder, one dividend bit per cycle
  assign rem_sh = {rem_q, dvd_q[VALUE_BITS-1]};
  assign rem_nx = (rem_sh >= p_q) ? rem_sh - p_q : rem_sh;

  assign start_v = (rem_q == '0) ? lo_c : lo_c + p_c - CW'(rem_q);
  assign start_m = (start_v < prod_c) ? prod_c : start_v;
  assign widx    = WA_W'(idx_q - lo_c);

  assign cnt_nx = (rd_pend_q && win_rd_q && cnt_q != COUNT_MAX) ? cnt_q + 1'b1 : cnt_q;

  always_comb begin
    state_d     = state_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    last_d      = last_q;
    k_d         = k_q;
    root_d      = root_q;
    rbit_d      = rbit_q;
    limit_d     = limit_q;
    idx_d       = idx_q;
    p_d         = p_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    dcnt_d      = dcnt_q;
    cnt_d       = cnt_nx;
    rd_pend_d   = 1'b0;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    base_we     = 1'b0;
    base_wa     = idx_q[BA_W-1:0];
    base_wd     = 1'b0;
    base_ra     = p_q[BA_W-1:0];
    win_we      = 1'b0;
    win_wa      = widx;
    win_wd      = 1'b0;
    win_ra      = k_q;

    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_empty) begin
            res_d   = '0;
            state_d = S_DONE;
          end else if (in_wide) begin
            res_d.prime_count = '0;
            res_d.range_error = 1'b1;
            state_d           = S_DONE;
          end else begin
            lo_d    = in_lo_c;
            hi_d    = in_hi;
            last_d  = in_span[WA_W-1:0];
            root_d  = '0;
            rbit_d  = RB_W'(ROOT_W - 1);
            state_d = S_SQRT;
          end
        end
      end
      S_SQRT: begin
        root_d = root_n;
        if (rbit_q == '0) begin
          if (CW'(root_n) > CW'(BASE_LIMIT - 1)) limit_d = BA_W'(BASE_LIMIT - 1);
          else limit_d = BA_W'(root_n);
          idx_d   = '0;
          state_d = S_BFILL;
        end else begin
          rbit_d = rbit_q - 1'b1;
        end
      end
      S_BFILL: begin
        base_we = 1'b1;
        base_wd = idx_q > CW'(1);
        if (idx_q == lim_c) begin
          p_d     = PW'(2);
          state_d = S_BTEST;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_BTEST: begin
        if (prod_c <= lim_c) begin
          state_d = S_BCHK;
        end else begin
          k_d     = '0;
          state_d = S_WFILL;
        end
      end
      S_BCHK: begin
        if (base_rd_q) begin
          idx_d   = prod_c;
          state_d = S_BMARK;
        end else begin
          p_d     = p_q + 1'b1;
          state_d = S_BTEST;
        end
      end
      S_BMARK: begin
        if (idx_q <= lim_c) begin
          base_we = 1'b1;
          idx_d   = idx_q + p_c;
        end else begin
          p_d     = p_q + 1'b1;
          state_d = S_BTEST;
        end
      end
      S_WFILL: begin
        win_we = 1'b1;
        win_wa = k_q;
        win_wd = 1'b1;
        if (k_q == last_q) begin
          p_d     = PW'(2);
          state_d = S_WTEST;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_WTEST: begin
        if (p_c > lim_c) begin
          k_d     = '0;
          cnt_d   = '0;
          state_d = S_CRD;
        end else begin
          state_d = S_WCHK;
        end
      end
      S_WCHK: begin
        if (base_rd_q) begin
          rem_d   = '0;
          dvd_d   = lo_q;
          dcnt_d  = DC_W'(VALUE_BITS - 1);
          state_d = S_DIV;
        end else begin
          p_d     = p_q + 1'b1;
          state_d = S_WTEST;
        end
      end
      S_DIV: begin
        rem_d = rem_nx[BA_W-1:0];
        dvd_d = dvd_q << 1;
        if (dcnt_q == '0) state_d = S_WSTART;
        else dcnt_d = dcnt_q - 1'b1;
      end
      S_WSTART: begin
        idx_d   = start_m;
        state_d = S_WMARK;
      end
      S_WMARK: begin
        if (idx_q <= hi_c) begin
          win_we = 1'b1;
          idx_d  = idx_q + p_c;
        end else begin
          p_d     = p_q + 1'b1;
          state_d = S_WTEST;
        end
      end
      S_CRD: begin
        rd_pend_d = 1'b1;
        if (k_q == last_q) state_d = S_CLAST;
        else k_d = k_q + 1'b1;
      end
      S_CLAST: begin
        res_d.prime_count = cnt_nx;
        res_d.range_error = 1'b0;
        state_d           = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (base_we) base_mem[base_wa] <= base_wd;
    base_rd_q <= base_mem[base_ra];
  end

  always_ff @(posedge clk_i) begin
    if (win_we) win_mem[win_wa] <= win_wd;
    win_rd_q <= win_mem[win_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    last_q  <= last_d;
    k_q     <= k_d;
    root_q  <= root_d;
    rbit_q  <= rbit_d;
    limit_q <= limit_d;
    idx_q   <= idx_d;
    p_q     <= p_d;
    rem_q   <= rem_d;
    dvd_q   <= dvd_d;
    dcnt_q  <= dcnt_d;
    cnt_q   <= cnt_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.range_error |-> out_data_o.prime_count == '0)
    else $error("range error word carries a nonzero count");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("accepted word did not start a query");

  a_mark_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WMARK && idx_q <= hi_c |-> (idx_q - lo_c) <= CW'(last_q))
    else $error("cross-off outside the window");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLAST |-> CW'(cnt_q) <= CW'(last_q))
    else $error("count exceeds the bits read");
`endif

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for segmented_prime_count
// Sends range queries through the valid/stall input channel and checks each
// result word against a segmented sieve computed in the bench. Directed
// corners come first, then random queries. Most random queries are
// well-formed ranges, mostly with small upper bounds; the rest are empty,
// too wide or fully random. Both sides idle at random in the first two of three phases.
// ----------------------------------------------------------------------------
module testbench;
  import spc_pkg::*;

  localparam int unsigned RANDOM_QUERIES = 81;
  localparam int unsigned IDLE_LIMIT     = 3_000_000;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned TAIL_CYCLES    = 50;

  logic     clk_i;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  spc_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  spc_out_t out_data_o;

  spc_in_t     query_queue[$];
  spc_out_t    count_expect[$];
  int unsigned total_queries;
  int unsigned queries_taken;
  int unsigned counts_seen;
  int unsigned failures;
  int unsigned idle_cycles;
  int unsigned wide_seen;
  int unsigned prime_total;

  bit base_mark[BASE_LIMIT];
  bit window_mark[WINDOW_SIZE];

  segmented_prime_count DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // both queues fill at the front and drain at the back
  function automatic void add_query(spc_in_t q);
    query_queue.push_front(q);
  endfunction

  function automatic void add_expect(spc_out_t r);
    count_expect.push_front(r);
  endfunction

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    longint unsigned cand;
    root = 0;
    bitv = 64'd1 << 31;
    while (bitv != 0) begin
      cand = root | bitv;
      if (cand * cand <= v) root = cand;
      bitv = bitv >> 1;
    end
    return root;
  endfunction

  function automatic spc_out_t count_primes(spc_in_t q);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned span;
    longint unsigned root;
    longint unsigned p;
    longint unsigned m;
    int unsigned     tally;
    spc_out_t        res;
    res = '0;
    lo  = q.low_bound;
    hi  = q.high_bound;
    if (lo > hi || hi < 2) return res;
    if (lo < 2) lo = 2;
    span = hi - lo + 1;
    if (span > WINDOW_SIZE) begin
      res.range_error = 1'b1;
      return res;
    end
    root = floor_root(hi);
    if (root > BASE_LIMIT - 1) root = BASE_LIMIT - 1;
    for (m = 0; m <= root; m++) base_mark[m] = 1'b1;
    base_mark[0] = 1'b0;
    base_mark[1] = 1'b0;
    for (p = 2; p * p <= root; p++) begin
      if (base_mark[p]) begin
        for (m = p * p; m <= root; m += p) base_mark[m] = 1'b0;
      end
    end
    for (m = 0; m < span; m++) window_mark[m] = 1'b1;
    for (p = 2; p <= root; p++) begin
      if (base_mark[p]) begin
        m = (lo + p - 1) / p * p;
        if (m < p * p) m = p * p;
        while (m <= hi) begin
          window_mark[m - lo] = 1'b0;
          m += p;
        end
      end
    end
    tally = 0;
    for (m = 0; m < span; m++) tally += window_mark[m];
    if (tally > COUNT_MAX) tally = COUNT_MAX;
    res.prime_count = tally[12:0];
    return res;
  endfunction

  function automatic spc_in_t random_query();
    int unsigned     roll;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned span;
    spc_in_t         q;
    roll = $urandom_range(0, 99);
    if (roll < 15) begin
      q.low_bound  = $urandom;
      q.high_bound = $urandom;
    end else if (roll < 20) begin
      q.low_bound  = $urandom_range(1, 32'hFFFF_FFFF);
      q.high_bound = $urandom_range(0, q.low_bound - 1);
    end else if (roll < 25) begin
      q.high_bound = $urandom_range(0, 1);
      q.low_bound  = $urandom_range(0, q.high_bound);
    end else if (roll < 35) begin
      lo = $urandom_range(0, 32'hFFFE_0000);
      hi = lo + WINDOW_SIZE + 2 + $urandom_range(0, 16'hFFFF);
      q.low_bound  = lo[31:0];
      q.high_bound = hi[31:0];
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 60) hi = $urandom_range(2, 65535);
      else if (roll < 90) hi = $urandom_range(65536, 1 << 22);
      else hi = $urandom_range((1 << 22) + 1, 1 << 24);
      roll = $urandom_range(0, 99);
      if (roll < 70) span = $urandom_range(1, 256);
      else if (roll < 90) span = $urandom_range(257, WINDOW_SIZE - 1);
      else span = WINDOW_SIZE;
      if (span > hi + 1) lo = $urandom_range(0, 1);
      else lo = hi + 1 - span;
      q.low_bound  = lo[31:0];
      q.high_bound = hi[31:0];
    end
    return q;
  endfunction

  function automatic int unsigned send_idle_pct();
    case (queries_taken * 3 / total_queries)
      0:       return 20;
      1:       return 67;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned recv_stall_pct();
    case (counts_seen * 3 / total_queries)
      0:       return 67;
      1:       return 20;
      default: return 0;
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        add_expect(count_primes(in_data_i));
        queries_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (query_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
          in_valid_i <= 1'b1;
          in_data_i  <= query_queue.pop_back();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    spc_out_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        counts_seen++;
        if (count_expect.size() == 0) begin
          if (failures < MAX_REPORTS)
            $display("unexpected word: count %0d error %0b",
                     out_data_o.prime_count, out_data_o.range_error);
          failures++;
        end else begin
          want = count_expect.pop_back();
          if (out_data_o.prime_count !== want.prime_count ||
              out_data_o.range_error !== want.range_error) begin
            if (failures < MAX_REPORTS)
              $display("mismatch on word %0d: expected count %0d error %0b, got count %0d error %0b",
                       counts_seen, want.prime_count, want.range_error,
                       out_data_o.prime_count, out_data_o.range_error);
            failures++;
          end
          wide_seen   += want.range_error;
          prime_total += want.prime_count;
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct());
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    // empty and low ranges
    add_query('{32'd0, 32'd0});
    add_query('{32'd0, 32'd1});
    add_query('{32'd5, 32'd3});
    add_query('{32'hFFFF_FFFF, 32'd0});
    // smallest ranges and single values
    add_query('{32'd1, 32'd2});
    add_query('{32'd2, 32'd2});
    add_query('{32'd3, 32'd3});
    add_query('{32'd4, 32'd4});
    add_query('{32'd49, 32'd49});
    add_query('{32'd97, 32'd97});
    add_query('{32'd2, 32'd100});
    // window edge, with and without raising the lower bound
    add_query('{32'd0, 32'd4097});
    add_query('{32'd0, 32'd4098});
    add_query('{32'd100, 32'd4195});
    add_query('{32'd100, 32'd4196});
    add_query('{32'd0, 32'hFFFF_FFFF});
    add_query('{32'hFFFF_E000, 32'hFFFF_FFFF});
    add_query('{32'd1_000_000, 32'd1_004_095});
    // top of the value range, largest 32-bit prime inside
    add_query('{32'hFFFF_FF00, 32'hFFFF_FFFF});
    repeat (RANDOM_QUERIES) add_query(random_query());
    total_queries = query_queue.size();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (queries_taken < total_queries || count_expect.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Checked %0d range queries (%0d too wide), %0d primes counted in total,",
             total_queries, wide_seen, prime_total);
    $display("under mixed sender idling and receiver stalls; %0d failures.", failures);
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== segmented_prime_count.f =====
rtl/core/spc_pkg.sv
rtl/core/segmented_prime_count.sv
bench/testbench.sv
